/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the timer statistics bank.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/itsb_pkg.sv */
// ----------------------------------------------------------------------------
// itsb_pkg
// Shared types and constants of the interval timer statistics bank.
// ----------------------------------------------------------------------------
`default_nettype none
package itsb_pkg;
  localparam int NUM_TIMERS_DEF  = 8;
  localparam int NUM_BUCKETS_DEF = 16;

  localparam logic [2:0] FUNC_INIT  = 3'd0;
  localparam logic [2:0] FUNC_RESET = 3'd1;
  localparam logic [2:0] FUNC_START = 3'd2;
  localparam logic [2:0] FUNC_STOP  = 3'd3;
  localparam logic [2:0] FUNC_QUERY = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;

  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

  // Per-timer statistics word held in the statistics memory.
  typedef struct packed {
    logic        running;
    logic        clk_type;
    logic [31:0] last;
    logic [31:0] count;
    logic [63:0] sum;
    logic [31:0] min;
    logic [31:0] max;
    logic [31:0] lo;
    logic [31:0] hi;
  } stat_t;

  localparam int STAT_W = $bits(stat_t);

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [37:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [37:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

/* rtl/itsb_ram.sv */
// ----------------------------------------------------------------------------
// itsb_ram
// Generic single-port-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module itsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/itsb_div.sv */
// ----------------------------------------------------------------------------
// itsb_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module itsb_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire itsb_pkg::div_req_t req,
  output itsb_pkg::div_rsp_t   rsp
);
  localparam int NW = 38;

  logic [NW-1:0] quo_r, quo_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   den_r, den_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [32:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[NW-1]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 6'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 32'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule
`default_nettype wire

/* rtl/interval_timer_stats_bank_top.sv */
// From acceptance, start, query and unknown operations pass S_READ and S_OUT; a read also
// waits in S_INIT for its histogram word; init and reset clear the histogram row in S_CLEAR,
// one word per cycle; a stop passes S_HRD and S_HWB, first S_DIV with the 38-step serial
// divider unless it lands in an end bucket. One item is in flight; a staging register holds
// its result while the previous result waits. Reset: synchronous active-low, then a clearing
// pass over NUM_BUCKETS words per timer slot (timer count rounded up to a power of two).
// ----------------------------------------------------------------------------
// interval_timer_stats_bank_top
// Bank of interval timers with count, sum, min, max and a histogram per timer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module interval_timer_stats_bank_top #(
  parameter int NUM_TIMERS  = itsb_pkg::NUM_TIMERS_DEF,
  parameter int NUM_BUCKETS = itsb_pkg::NUM_BUCKETS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // func[2:0], timer_index[5:3], time_now[37:6], bucket_low[69:38],
  // bucket_high[101:70], clock_type[102], bucket_index[106:103], zero pad
  input  wire logic [111:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // value[31:0], sample_total[63:32], elapsed_sum[127:64], shortest[159:128],
  // longest[191:160], bucket_count[223:192], is_running[224], is_clock[225],
  // zero pad
  output logic [231:0]      out_tdata
);
  localparam int TW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int BW  = $clog2(NUM_BUCKETS);
  localparam int SD  = 1 << TW;
  localparam int HDP = SD * NUM_BUCKETS;
  localparam int HWP = $clog2(HDP);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_HRD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_INIT  = 3'd6;
  localparam logic [2:0] S_HWB   = 3'd7;

  // Input fields.
  logic [2:0]  f_func;
  logic [2:0]  f_tidx;
  logic [31:0] f_now, f_blo, f_bhi;
  logic        f_ctype;
  logic [3:0]  f_bsel;
  assign f_func  = in_tdata[2:0];
  assign f_tidx  = in_tdata[5:3];
  assign f_now   = in_tdata[37:6];
  assign f_blo   = in_tdata[69:38];
  assign f_bhi   = in_tdata[101:70];
  assign f_ctype = in_tdata[102];
  assign f_bsel  = in_tdata[106:103];

  logic [2:0]  st_r, st_nxt;
  logic [2:0]  func_r;
  logic [TW-1:0] tidx_r;
  logic        inrange_r;
  logic [31:0] now_r, blo_r, bhi_r;
  logic        ctype_r;
  logic [3:0]  bsel_r;
  logic [HWP-1:0] cptr_r, cptr_nxt;
  logic        boot_r;
  logic [BW-1:0] bucket_r;
  logic        out_valid_r;
  logic [231:0] out_data_r;
  logic [231:0] res_r;

  itsb_pkg::stat_t stat_rd, stat_wr;
  logic            stat_we;
  logic [TW-1:0]   stat_waddr, stat_raddr;
  logic [31:0]     hist_rd, hist_wd;
  logic            hist_we;
  logic [HWP-1:0]  hist_waddr, hist_raddr;

  itsb_pkg::div_req_t dreq;
  itsb_pkg::div_rsp_t drsp;

  itsb_ram #(.WIDTH(itsb_pkg::STAT_W), .DEPTH(SD)) u_stat (
    .clk(clk), .we(stat_we), .waddr(stat_waddr), .wdata(stat_wr),
    .raddr(stat_raddr), .rdata(stat_rd)
  );
  itsb_ram #(.WIDTH(32), .DEPTH(HDP)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wd),
    .raddr(hist_raddr), .rdata(hist_rd)
  );
  itsb_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // An item is taken only when idle and out of the reset sweep. The finished
  // result of the previous item may still wait in the output register, since
  // the working result is staged separately until the output slot frees.
  assign in_tready  = (st_r == S_IDLE) && !boot_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic accept;
  assign accept = in_tvalid && in_tready;

  // The staged result moves to the output once the slot is empty or drains.
  logic out_load;
  assign out_load = (st_r == S_OUT) && (!out_valid_r || out_tready);

  // Cleared statistics word, keeping bounds and type.
  function automatic itsb_pkg::stat_t cleared(input itsb_pkg::stat_t s);
    itsb_pkg::stat_t c;
    c         = s;
    c.running = 1'b0;
    c.last    = '0;
    c.count   = '0;
    c.sum     = '0;
    c.min     = itsb_pkg::ALL_ONES32;
    c.max     = '0;
    return c;
  endfunction

  logic [31:0] e_now, q_elapsed, span, off;
  logic [HWP-1:0] row_base;
  logic [37:0] quo_sat;
  assign e_now     = now_r - stat_rd.last;
  assign q_elapsed = (now_r > stat_rd.last) ? (now_r - stat_rd.last)
                                            : (now_r + (itsb_pkg::ALL_ONES32 - stat_rd.last));
  assign span      = stat_rd.hi - stat_rd.lo;
  assign off       = e_now - stat_rd.lo;
  assign row_base  = HWP'(tidx_r) * HWP'(NUM_BUCKETS);
  assign quo_sat   = drsp.quo + 38'd1;

  // A read merges the histogram word that arrives while the item sits in S_OUT.
  logic          bucket_hit;
  logic [231:0]  res_out;
  assign bucket_hit = (func_r == itsb_pkg::FUNC_READ) && inrange_r
                      && (32'(bsel_r) < 32'(NUM_BUCKETS));
  assign res_out    = {res_r[231:224], bucket_hit ? hist_rd : res_r[223:192], res_r[191:0]};

  logic [BW-1:0] bucket_nxt;
  logic [231:0]  res_nxt;
  logic          res_ld;
  logic [BW-1:0] bucket_ld;
  logic          bucket_set;

  always_comb begin
    st_nxt     = st_r;
    cptr_nxt   = cptr_r;
    stat_we    = 1'b0;
    stat_waddr = tidx_r;
    stat_wr    = stat_rd;
    stat_raddr = accept ? TW'(f_tidx) : tidx_r;
    hist_we    = 1'b0;
    hist_waddr = cptr_r;
    hist_wd    = '0;
    hist_raddr = row_base + HWP'(bucket_r);
    dreq       = '0;
    res_ld     = 1'b0;
    res_nxt    = '0;
    bucket_set = 1'b0;
    bucket_ld  = '0;
    bucket_nxt = bucket_r;
    if (boot_r) begin
      hist_we  = 1'b1;
      stat_we  = (cptr_r < HWP'(SD));
      stat_waddr = cptr_r[TW-1:0];
      stat_wr  = cleared('0);
      cptr_nxt = cptr_r + HWP'(1);
    end else begin
      case (st_r)
        S_IDLE: begin
          if (accept) st_nxt = S_READ;
        end
        S_READ: begin
          if (!inrange_r) begin
            res_ld = 1'b1;
            st_nxt = S_OUT;
          end else begin
            case (func_r)
              itsb_pkg::FUNC_INIT, itsb_pkg::FUNC_RESET: begin
                stat_we = 1'b1;
                stat_wr = cleared(stat_rd);
                if (func_r == itsb_pkg::FUNC_INIT) begin
                  stat_wr.lo       = blo_r;
                  stat_wr.hi       = bhi_r;
                  stat_wr.clk_type = ctype_r;
                end
                cptr_nxt = row_base;
                res_ld = 1'b1;
                res_nxt[225] = stat_wr.clk_type;
                st_nxt = S_CLEAR;
              end
              itsb_pkg::FUNC_START: begin
                stat_we = 1'b1;
                stat_wr.running = 1'b1;
                stat_wr.last    = now_r;
                res_ld = 1'b1;
                res_nxt[31:0] = now_r;
                res_nxt[224]  = 1'b1;
                res_nxt[225]  = stat_rd.clk_type;
                st_nxt = S_OUT;
              end
              itsb_pkg::FUNC_STOP: begin
                stat_we = 1'b1;
                stat_wr.running = 1'b0;
                stat_wr.last    = e_now;
                stat_wr.sum     = stat_rd.sum + {32'd0, e_now};
                stat_wr.count   = stat_rd.count + 32'd1;
                if (stat_rd.min > e_now) stat_wr.min = e_now;
                if (stat_rd.max < e_now) stat_wr.max = e_now;
                res_ld = 1'b1;
                res_nxt[31:0] = e_now;
                res_nxt[225]  = stat_rd.clk_type;
                bucket_set = 1'b1;
                if (e_now <= stat_rd.lo) begin
                  bucket_ld = '0;
                  st_nxt = S_HRD;
                end else if (e_now >= stat_rd.hi) begin
                  bucket_ld = BW'(NUM_BUCKETS - 1);
                  st_nxt = S_HRD;
                end else begin
                  dreq.start = 1'b1;
                  dreq.num   = {6'd0, off} * 38'(NUM_BUCKETS - 2);
                  dreq.den   = span;
                  st_nxt = S_DIV;
                end
              end
              itsb_pkg::FUNC_QUERY: begin
                res_ld = 1'b1;
                if (stat_rd.clk_type) res_nxt[31:0] = q_elapsed;
                res_nxt[224] = stat_rd.running;
                res_nxt[225] = stat_rd.clk_type;
                st_nxt = S_OUT;
              end
              itsb_pkg::FUNC_READ: begin
                res_ld = 1'b1;
                res_nxt[31:0]    = stat_rd.last;
                res_nxt[63:32]   = stat_rd.count;
                res_nxt[127:64]  = stat_rd.sum;
                res_nxt[159:128] = stat_rd.min;
                res_nxt[191:160] = stat_rd.max;
                res_nxt[224]     = stat_rd.running;
                res_nxt[225]     = stat_rd.clk_type;
                if (32'(bsel_r) < 32'(NUM_BUCKETS)) begin
                  bucket_set = 1'b1;
                  bucket_ld  = BW'(bsel_r);
                  st_nxt = S_INIT;
                end else begin
                  st_nxt = S_OUT;
                end
              end
              default: begin
                res_ld = 1'b1;
                res_nxt[224] = stat_rd.running;
                res_nxt[225] = stat_rd.clk_type;
                st_nxt = S_OUT;
              end
            endcase
          end
        end
        S_CLEAR: begin
          hist_we  = 1'b1;
          cptr_nxt = cptr_r + HWP'(1);
          if (cptr_r == row_base + HWP'(NUM_BUCKETS - 1)) st_nxt = S_OUT;
        end
        S_DIV: begin
          if (drsp.done) begin
            bucket_set = 1'b1;
            bucket_ld  = (quo_sat > 38'(NUM_BUCKETS - 1)) ? BW'(NUM_BUCKETS - 1)
                                                           : BW'(quo_sat);
            st_nxt = S_HRD;
          end
        end
        S_HRD: st_nxt = S_HWB;
        S_HWB: begin
          hist_we    = 1'b1;
          hist_waddr = row_base + HWP'(bucket_r);
          hist_wd    = hist_rd + 32'd1;
          st_nxt     = S_OUT;
        end
        S_INIT: st_nxt = S_OUT;   // histogram word is read
        S_OUT: begin
          if (out_load) st_nxt = S_IDLE;
        end
        default: st_nxt = S_IDLE;
      endcase
    end
    if (bucket_set) bucket_nxt = bucket_ld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      boot_r      <= 1'b1;
      cptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cptr_r <= cptr_nxt;
      if (boot_r && cptr_r == HWP'(HDP - 1)) boot_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    bucket_r <= bucket_nxt;
    if (accept) begin
      func_r    <= f_func;
      tidx_r    <= TW'(f_tidx);
      inrange_r <= (32'(f_tidx) < 32'(NUM_TIMERS));
      now_r     <= f_now;
      blo_r     <= f_blo;
      bhi_r     <= f_bhi;
      ctype_r   <= f_ctype;
      bsel_r    <= f_bsel;
    end
    if (res_ld) res_r <= res_nxt;
    if (out_load) out_data_r <= res_out;
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, accept, st_r == S_IDLE && !boot_r,
               "input accepted while an item is in flight")
  `ASSERT_NEXT(a_out_after_work, clk, rst_n, out_load, out_valid_r,
               "finished item did not raise the output")
  `ASSERT_IMPL(a_no_work_in_boot, clk, rst_n, boot_r, !in_tready,
               "input ready during clearing pass")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_tready,
               out_valid_r && $stable(out_data_r), "stalled result beat changed")
endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the interval timer statistics bank: a directed
// sequence, then random timer sessions, with a predictor checking every beat.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  localparam int NT = 8;
  localparam int NB = 16;
  localparam longint CYCLE_LIMIT = 600000;

  // Operation codes that the block does not define.
  localparam logic [2:0] FUNC_UNDEF_A = 3'd6;
  localparam logic [2:0] FUNC_UNDEF_B = 3'd7;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [231:0] out_tdata;

  interval_timer_stats_bank_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct packed {
    logic [3:0]  bsel;
    logic        ctype;
    logic [31:0] bhi;
    logic [31:0] blo;
    logic [31:0] now;
    logic [2:0]  tmr;
    logic [2:0]  func;
  } cmd_t;

  typedef struct packed {
    logic        is_clock;
    logic        is_running;
    logic [31:0] bucket_count;
    logic [31:0] longest;
    logic [31:0] shortest;
    logic [63:0] elapsed_sum;
    logic [31:0] sample_total;
    logic [31:0] value;
  } stat_rsp_t;

  // Predictor state of the timer bank.
  logic        p_run   [NT];
  logic        p_clk   [NT];
  logic [31:0] p_last  [NT];
  logic [31:0] p_cnt   [NT];
  logic [63:0] p_sum   [NT];
  logic [31:0] p_min   [NT];
  logic [31:0] p_max   [NT];
  logic [31:0] p_lo    [NT];
  logic [31:0] p_hi    [NT];
  logic [31:0] p_hist  [NT][NB];

  cmd_t      pending_cmds[$];
  stat_rsp_t expected_rsps[$];
  int        fail_count = 0;
  int        send_idle_pct = 37;
  int        recv_idle_pct = 48;
  int        hold_off_cycles = 0;
  logic      hold_off_req = 1'b0;
  logic      hold_off_done = 1'b0;
  longint    cycle_count = 0;
  logic      in_tready_seen;

  function automatic void clear_timer(int t);
    p_run[t] = 1'b0; p_last[t] = '0; p_cnt[t] = '0; p_sum[t] = '0;
    p_min[t] = itsb_pkg::ALL_ONES32; p_max[t] = '0;
    for (int b = 0; b < NB; b++) p_hist[t][b] = '0;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < NT; i++) begin
      p_lo[i] = '0; p_hi[i] = '0; p_clk[i] = 1'b0;
      clear_timer(i);
    end
  endfunction

  function automatic int bucket_for(int t, logic [31:0] e);
    logic [63:0] q;
    if (e <= p_lo[t]) return 0;
    if (e >= p_hi[t]) return NB - 1;
    q = (64'(e - p_lo[t]) * 64'(NB - 2)) / 64'(p_hi[t] - p_lo[t]) + 64'd1;
    if (q > 64'(NB - 1)) q = 64'(NB - 1);
    return int'(q);
  endfunction

  function automatic stat_rsp_t apply_cmd(cmd_t c);
    stat_rsp_t r;
    logic [31:0] e;
    int t;
    r = '0;
    t = int'(c.tmr);
    case (c.func)
      itsb_pkg::FUNC_INIT: begin
        p_lo[t] = c.blo; p_hi[t] = c.bhi; p_clk[t] = c.ctype;
        clear_timer(t);
      end
      itsb_pkg::FUNC_RESET: clear_timer(t);
      itsb_pkg::FUNC_START: begin
        p_run[t] = 1'b1; p_last[t] = c.now; r.value = c.now;
      end
      itsb_pkg::FUNC_STOP: begin
        p_run[t] = 1'b0;
        e = c.now - p_last[t];
        p_last[t] = e;
        p_sum[t] += 64'(e);
        p_cnt[t] += 32'd1;
        if (p_min[t] > e) p_min[t] = e;
        if (p_max[t] < e) p_max[t] = e;
        p_hist[t][bucket_for(t, e)] += 32'd1;
        r.value = e;
      end
      itsb_pkg::FUNC_QUERY: begin
        // Clock timers use the off-by-one wrap formula when wrapped.
        if (p_clk[t]) begin
          if (c.now > p_last[t]) r.value = c.now - p_last[t];
          else r.value = c.now + (itsb_pkg::ALL_ONES32 - p_last[t]);
        end
      end
      itsb_pkg::FUNC_READ: begin
        r.value = p_last[t]; r.sample_total = p_cnt[t]; r.elapsed_sum = p_sum[t];
        r.shortest = p_min[t]; r.longest = p_max[t];
        r.bucket_count = p_hist[t][c.bsel];
      end
      default: ;
    endcase
    r.is_running = p_run[t];
    r.is_clock = p_clk[t];
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] f, logic [2:0] t, logic [31:0] now);
    cmd_t c;
    c.func = f; c.tmr = t; c.now = now;
    c.blo = $urandom; c.bhi = $urandom; c.ctype = 1'($urandom_range(0, 1));
    c.bsel = 4'($urandom_range(0, 15));
    return c;
  endfunction

  function automatic void push_init(logic [2:0] t, logic [31:0] lo, logic [31:0] hi,
                                    logic ct);
    cmd_t c;
    c = make_cmd(itsb_pkg::FUNC_INIT, t, $urandom);
    c.blo = lo; c.bhi = hi; c.ctype = ct;
    pending_cmds.push_back(c);
  endfunction

  // Clock: period 8.
  initial clk = 0;
  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Driver: offers the next pending item, changing inputs on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready_seen) begin
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tdata  <= {5'd0, pending_cmds.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Beat acceptance seen at the rising edge; the predictor runs here.
  always @(posedge clk) begin
    in_tready_seen <= 1'b0;
    if (!rst_n) begin
      reset_model();
    end else if (in_tvalid && in_tready) begin
      expected_rsps.push_back(apply_cmd(cmd_t'(in_tdata[106:0])));
      in_tready_seen <= 1'b1;
    end
  end

  // Receiver back pressure, with one long hold-off counted here.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (hold_off_req && !hold_off_done) begin
      out_tready <= 1'b0;
      hold_off_cycles <= 400;
      hold_off_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each result beat with the oldest expectation.
  always @(posedge clk) begin
    stat_rsp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = stat_rsp_t'(out_tdata[225:0]);
      if (expected_rsps.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (got.value !== want.value) begin
          $error("value exp %h got %h", want.value, got.value); fail_count++;
        end
        if (got.sample_total !== want.sample_total) begin
          $error("sample_total exp %h got %h", want.sample_total, got.sample_total);
          fail_count++;
        end
        if (got.elapsed_sum !== want.elapsed_sum) begin
          $error("elapsed_sum exp %h got %h", want.elapsed_sum, got.elapsed_sum);
          fail_count++;
        end
        if (got.shortest !== want.shortest) begin
          $error("shortest exp %h got %h", want.shortest, got.shortest); fail_count++;
        end
        if (got.longest !== want.longest) begin
          $error("longest exp %h got %h", want.longest, got.longest); fail_count++;
        end
        if (got.bucket_count !== want.bucket_count) begin
          $error("bucket_count exp %h got %h", want.bucket_count, got.bucket_count);
          fail_count++;
        end
        if (got.is_running !== want.is_running) begin
          $error("is_running exp %b got %b", want.is_running, got.is_running);
          fail_count++;
        end
        if (got.is_clock !== want.is_clock) begin
          $error("is_clock exp %b got %b", want.is_clock, got.is_clock); fail_count++;
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [2:0]  t;
    logic [31:0] base, lo;
    int n;
    int total;
    rst_n = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // Directed part: bounds extremes, inverted and equal bounds, every func,
    // wrapping intervals, the query wrap formula and unknown funcs.
    push_init(3'd0, 32'd100, 32'd1700, 1'b1);
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_START, 3'd0, 32'hFFFF_FFF0));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_QUERY, 3'd0, 32'h0000_0010));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_QUERY, 3'd0, 32'hFFFF_FFF0));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_STOP, 3'd0, 32'h0000_0400));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_START, 3'd0, 32'd0));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_STOP, 3'd0, 32'd100));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_START, 3'd0, 32'd0));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_STOP, 3'd0, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_STOP, 3'd0, 32'hFFFF_FFFF));
    for (int b = 0; b < NB; b += 5) begin
      cmd_t c;
      c = make_cmd(itsb_pkg::FUNC_READ, 3'd0, 32'd0); c.bsel = 4'(b);
      pending_cmds.push_back(c);
    end
    push_init(3'd1, 32'hFFFF_FFFF, 32'd0, 1'b0);
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_STOP, 3'd1, 32'd77));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_QUERY, 3'd1, 32'd5));
    push_init(3'd7, 32'd50, 32'd50, 1'b1);
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_STOP, 3'd7, 32'd50));
    pending_cmds.push_back(make_cmd(FUNC_UNDEF_A, 3'd7, 32'd1));
    pending_cmds.push_back(make_cmd(FUNC_UNDEF_B, 3'd0, 32'd1));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_RESET, 3'd0, 32'd0));
    pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_READ, 3'd0, 32'd0));

    // Random part: sessions of start/stop pairs with nearby bounds, plus noise.
    n = 0;
    while (n < 1530) begin
      t = 3'($urandom_range(0, NT - 1));
      case ($urandom_range(0, 9))
        0: begin
          lo = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000);
          push_init(t, lo, lo + $urandom_range(0, 30000), 1'($urandom_range(0, 1)));
          n++;
        end
        1: begin
          pending_cmds.push_back(make_cmd(3'($urandom_range(0, 7)), t, $urandom));
          n++;
        end
        2: begin pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_RESET, t, $urandom)); n++; end
        default: begin
          base = $urandom;
          pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_START, t, base));
          if ($urandom_range(0, 1)) begin
            pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_QUERY, t,
                                            base + $urandom_range(0, 40000)));
            n++;
          end
          pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_STOP, t,
                                          base + $urandom_range(0, 40000)));
          pending_cmds.push_back(make_cmd(itsb_pkg::FUNC_READ, t, $urandom));
          n += 3;
        end
      endcase
    end

    // Traffic phases follow the progress of the driver.
    total = pending_cmds.size();
    wait (pending_cmds.size() <= total - 300);
    hold_off_req = 1'b1;
    wait (pending_cmds.size() <= total - total / 3);
    send_idle_pct = 48; recv_idle_pct = 37;
    wait (pending_cmds.size() <= total - 2 * (total / 3));
    send_idle_pct = 0; recv_idle_pct = 0;

    wait (pending_cmds.size() == 0 && !in_tvalid);
    wait (expected_rsps.size() == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
